### src/pcse_pkg.sv
// Package for the piecewise cubic spline evaluator.
// Holds widths, status codes, queue entry and state types used by all modules but pcse_ram.
// Depends on nothing.
package pcse_pkg;

  localparam int MAX_POINTS     = 32;
  localparam int NUM_CURVES     = 3;
  localparam int COEF_WIDTH     = 40;
  localparam int DIST_FRAC_BITS = 16;
  localparam int DIST_WIDTH     = 8 + DIST_FRAC_BITS;
  localparam int SPEED_WIDTH    = 32;
  localparam int SPEED_SHIFT    = 8;
  localparam int CFG_WIDTH      = 6;
  localparam int NREGS          = 3;
  localparam int CURVE_WIDTH    = 2;
  localparam int IDX_WIDTH      = 5;
  localparam int STORE_DEPTH    = NUM_CURVES * MAX_POINTS;
  localparam int ADDR_WIDTH     = $clog2(STORE_DEPTH);
  localparam int CNT_WIDTH      = $clog2(MAX_POINTS + 1);
  localparam int PROD_WIDTH     = COEF_WIDTH + DIST_WIDTH + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ROW_WIDTH      = DIST_WIDTH + 4 * COEF_WIDTH;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BELOW     = 3'd1,
    ST_ABOVE     = 3'd2,
    ST_NOT_LOAD  = 3'd3,
    ST_WRITE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_RD_FIRST, BK_CHK_FIRST, BK_CHK_LAST, BK_SEARCH, BK_SEARCH_WAIT,
    BK_FETCH, BK_FETCH_WAIT, BK_MUL, BK_ADD, BK_DONE
  } bk_state_t;

  typedef enum logic [0:0] { OP_WRITE = 1'b0, OP_EVAL = 1'b1 } op_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] knot;
    logic [COEF_WIDTH-1:0] a;
    logic [COEF_WIDTH-1:0] b;
    logic [COEF_WIDTH-1:0] c;
    logic [COEF_WIDTH-1:0] d;
  } row_t;

  typedef struct packed {
    logic                  is_eval;
    logic [ADDR_WIDTH-1:0] base;
    logic [CNT_WIDTH-1:0]  num;
    logic [DIST_WIDTH-1:0] query;
    logic [IDX_WIDTH-1:0]  entry;
    row_t                  row;
  } job_t;

endpackage

### src/pcse_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pcse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/pcse_front.sv
// Front part: accepts items, resolves the curve and count, and pushes one
// job per item into a short queue. Depends on pcse_pkg.
module pcse_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [pcse_pkg::CURVE_WIDTH-1:0]  in_curve,
  input  logic [pcse_pkg::IDX_WIDTH-1:0]    in_entry_index,
  input  logic [pcse_pkg::DIST_WIDTH-1:0]   in_knot_distance,
  input  logic [pcse_pkg::COEF_WIDTH-1:0]   in_coef_cubic,
  input  logic [pcse_pkg::COEF_WIDTH-1:0]   in_coef_square,
  input  logic [pcse_pkg::COEF_WIDTH-1:0]   in_coef_linear,
  input  logic [pcse_pkg::COEF_WIDTH-1:0]   in_coef_const,
  input  logic [pcse_pkg::DIST_WIDTH-1:0]   in_query_distance,
  input  logic [pcse_pkg::CFG_WIDTH-1:0]    points_r [pcse_pkg::NREGS],
  output logic                              job_valid,
  input  logic                              job_ready,
  output pcse_pkg::job_t                    job
);
  import pcse_pkg::*;

  job_t                      q_r [QUEUE_DEPTH];
  logic [1:0]                cnt_r;
  logic                      wp_r, rp_r;
  logic [CURVE_WIDTH-1:0]    cv;
  logic [ADDR_WIDTH-1:0]     base;
  logic [CFG_WIDTH-1:0]      nraw;
  logic [CNT_WIDTH-1:0]      num;
  job_t                      nj;
  logic                      push, pop;

  always_comb begin
    cv = (in_curve >= CURVE_WIDTH'(NUM_CURVES)) ? '0 : in_curve;
    base = ADDR_WIDTH'(cv) * ADDR_WIDTH'(MAX_POINTS);
    nraw = (int'(cv) < NREGS) ? points_r[cv] : '0;
    num = (nraw > CFG_WIDTH'(MAX_POINTS)) ? CNT_WIDTH'(MAX_POINTS) : CNT_WIDTH'(nraw);
    nj.is_eval = (in_op == OP_EVAL);
    nj.base = base;
    nj.num = num;
    nj.query = in_query_distance;
    nj.entry = in_entry_index;
    nj.row = '{knot: in_knot_distance, a: in_coef_cubic, b: in_coef_square,
               c: in_coef_linear, d: in_coef_const};
  end

  assign in_ready  = (cnt_r != 2'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= nj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/pcse_back.sv
// Back part: table writes in item order, range checks, binary search and Horner
// evaluation. Uses the table RAM through one write and one registered read port.
// Depends on pcse_pkg.
module pcse_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  pcse_pkg::job_t                    job,
  output logic                              wr_en,
  output logic [pcse_pkg::ADDR_WIDTH-1:0]   wr_addr,
  output pcse_pkg::row_t                    wr_row,
  output logic [pcse_pkg::ADDR_WIDTH-1:0]   rd_addr,
  input  pcse_pkg::row_t                    rd_row,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcse_pkg::SPEED_WIDTH-1:0]  out_speed,
  output logic [pcse_pkg::IDX_WIDTH-1:0]    out_segment,
  output logic [2:0]                        out_status
);
  import pcse_pkg::*;

  localparam logic signed [COEF_WIDTH-1:0] CMAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] CMIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  bk_state_t state_r, state_nxt;
  job_t      job_r, job_nxt;
  logic [CNT_WIDTH-1:0] left_r, left_nxt, right_r, right_nxt, mid_r, mid_nxt;
  logic [1:0] step_r, step_nxt;
  logic signed [COEF_WIDTH-1:0] acc_r, acc_nxt;
  row_t       row_r, row_nxt;
  logic [DIST_WIDTH-1:0] dx_r, dx_nxt;
  logic       oval_r, oval_nxt;
  logic [SPEED_WIDTH-1:0] osp_r, osp_nxt;
  logic [IDX_WIDTH-1:0]   oseg_r, oseg_nxt;
  logic [2:0]             ost_r, ost_nxt;

  logic signed [PROD_WIDTH+DIST_WIDTH-1:0] pfull;
  logic signed [PROD_WIDTH-1:0]            psh;
  logic signed [COEF_WIDTH-1:0]            mres, addend;
  logic signed [COEF_WIDTH:0]              sum;
  logic signed [COEF_WIDTH-SPEED_SHIFT-1:0] sp;
  logic [CNT_WIDTH-1:0]                    midc;

  assign out_valid   = oval_r;
  assign out_speed   = osp_r;
  assign out_segment = oseg_r;
  assign out_status  = ost_r;

  assign wr_addr = job.base + ADDR_WIDTH'(job.entry);
  assign wr_row  = job.row;

  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    left_nxt = left_r;
    right_nxt = right_r;
    mid_nxt = mid_r;
    step_nxt = step_r;
    acc_nxt = acc_r;
    row_nxt = row_r;
    dx_nxt = dx_r;
    oval_nxt = oval_r;
    osp_nxt = osp_r;
    oseg_nxt = oseg_r;
    ost_nxt = ost_r;
    job_ready = 1'b0;
    wr_en = 1'b0;
    rd_addr = job_r.base;
    midc = CNT_WIDTH'((left_r + right_r) >> 1) + CNT_WIDTH'(1);
    pfull = acc_r * $signed({1'b0, dx_r});
    psh = PROD_WIDTH'(pfull >>> DIST_FRAC_BITS);
    if (psh > PROD_WIDTH'(CMAX)) mres = CMAX;
    else if (psh < PROD_WIDTH'(CMIN)) mres = CMIN;
    else mres = COEF_WIDTH'(psh);
    case (step_r)
      2'd0: addend = row_r.b;
      2'd1: addend = row_r.c;
      default: addend = row_r.d;
    endcase
    sum = {acc_r[COEF_WIDTH-1], acc_r} + {addend[COEF_WIDTH-1], addend};
    sp = acc_r[COEF_WIDTH-1:SPEED_SHIFT];
    if (oval_r && out_ready) oval_nxt = 1'b0;
    case (state_r)
      BK_IDLE: begin
        job_ready = !oval_r || out_ready;
        if (job_valid && job_ready) begin
          job_nxt = job;
          if (!job.is_eval) begin
            wr_en = (int'(job.entry) < MAX_POINTS);
            osp_nxt = '0; oseg_nxt = '0; ost_nxt = ST_WRITE;
            state_nxt = BK_DONE;
          end else if (job.num < CNT_WIDTH'(2)) begin
            osp_nxt = '0; oseg_nxt = '0; ost_nxt = ST_NOT_LOAD;
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_RD_FIRST;
          end
        end
      end
      BK_RD_FIRST: begin
        rd_addr = job_r.base;
        state_nxt = BK_CHK_FIRST;
      end
      BK_CHK_FIRST: begin
        rd_addr = job_r.base + ADDR_WIDTH'(job_r.num - CNT_WIDTH'(1));
        if (job_r.query < rd_row.knot) begin
          osp_nxt = '0; oseg_nxt = '0; ost_nxt = ST_BELOW;
          state_nxt = BK_DONE;
        end else begin
          state_nxt = BK_CHK_LAST;
        end
      end
      BK_CHK_LAST: begin
        if (job_r.query > rd_row.knot) begin
          osp_nxt = '0; oseg_nxt = '0; ost_nxt = ST_ABOVE;
          state_nxt = BK_DONE;
        end else begin
          left_nxt = '0;
          right_nxt = job_r.num - CNT_WIDTH'(1);
          state_nxt = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (left_r < right_r) begin
          mid_nxt = midc;
          rd_addr = job_r.base + ADDR_WIDTH'(midc);
          state_nxt = BK_SEARCH_WAIT;
        end else begin
          state_nxt = BK_FETCH;
        end
      end
      BK_SEARCH_WAIT: begin
        if (job_r.query <= rd_row.knot) right_nxt = mid_r - CNT_WIDTH'(1);
        else left_nxt = mid_r;
        state_nxt = BK_SEARCH;
      end
      BK_FETCH: begin
        rd_addr = job_r.base + ADDR_WIDTH'(left_r);
        state_nxt = BK_FETCH_WAIT;
      end
      BK_FETCH_WAIT: begin
        row_nxt = rd_row;
        dx_nxt = (job_r.query >= rd_row.knot) ? job_r.query - rd_row.knot : '0;
        acc_nxt = rd_row.a;
        step_nxt = '0;
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        acc_nxt = mres;
        state_nxt = BK_ADD;
      end
      BK_ADD: begin
        if (sum > $signed({CMAX[COEF_WIDTH-1], CMAX})) acc_nxt = CMAX;
        else if (sum < $signed({CMIN[COEF_WIDTH-1], CMIN})) acc_nxt = CMIN;
        else acc_nxt = COEF_WIDTH'(sum);
        if (step_r == 2'd2) begin
          state_nxt = BK_DONE;
          ost_nxt = ST_OK;
          oseg_nxt = IDX_WIDTH'(left_r);
        end else begin
          step_nxt = step_r + 2'd1;
          state_nxt = BK_MUL;
        end
      end
      BK_DONE: begin
        if (ost_r == ST_OK && !oval_r) begin
          if (sp > $signed(SPEED_WIDTH'({1'b0, {(SPEED_WIDTH-1){1'b1}}})))
            osp_nxt = {1'b0, {(SPEED_WIDTH-1){1'b1}}};
          else if (sp < $signed({1'b1, {(SPEED_WIDTH-1){1'b0}}}))
            osp_nxt = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
          else osp_nxt = SPEED_WIDTH'(sp);
        end
        if (!oval_r) begin
          oval_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    mid_r   <= mid_nxt;
    step_r  <= step_nxt;
    acc_r   <= acc_nxt;
    row_r   <= row_nxt;
    dx_r    <= dx_nxt;
    osp_r   <= osp_nxt;
    oseg_r  <= oseg_nxt;
    ost_r   <= ost_nxt;
  end

endmodule

### src/piecewise_cubic_spline_eval_core.sv
// Top level of the piecewise cubic spline evaluator.
// Instantiates pcse_front, pcse_back and one pcse_ram; uses pcse_pkg.
//
// Usage: items enter on the in_ channel (valid/ready). A write item stores a
// knot and four coefficients in the selected curve's table; an evaluate item
// returns the cubic at the query distance on the out_ channel, one result
// beat per item, in order. Knot counts are written on the cfg_ port while
// the block is idle.
// A front part accepts items into a two-entry queue; a back part takes one
// job at a time, performs table writes in item order, and runs the range
// checks, a binary search and three Horner multiply-add steps, all through
// one registered RAM read port.
// The back part takes a new item only from its idle state, and only while the
// result register is empty or being read, so it finishes each item first.
// Reset clears the queue, the back-end state, the result valid flag and the
// knot counts; the tables hold no reset. When the receiver stalls, the
// result is held and the queue keeps filling until it is full.
module piecewise_cubic_spline_eval_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [pcse_pkg::CURVE_WIDTH-1:0]  in_curve,
  input  logic [pcse_pkg::IDX_WIDTH-1:0]    in_entry_index,
  input  logic [pcse_pkg::DIST_WIDTH-1:0]   in_knot_distance,
  input  logic signed [pcse_pkg::COEF_WIDTH-1:0] in_coef_cubic,
  input  logic signed [pcse_pkg::COEF_WIDTH-1:0] in_coef_square,
  input  logic signed [pcse_pkg::COEF_WIDTH-1:0] in_coef_linear,
  input  logic signed [pcse_pkg::COEF_WIDTH-1:0] in_coef_const,
  input  logic [pcse_pkg::DIST_WIDTH-1:0]   in_query_distance,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pcse_pkg::SPEED_WIDTH-1:0] out_speed,
  output logic [pcse_pkg::IDX_WIDTH-1:0]    out_segment,
  output logic [2:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [pcse_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import pcse_pkg::*;

  logic [CFG_WIDTH-1:0]  points_r [NREGS];
  logic                  wr_en;
  logic [ADDR_WIDTH-1:0] wr_addr, rd_addr;
  row_t                  wr_row, rd_row;
  logic                  job_valid, job_ready;
  job_t                  job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS; i++) points_r[i] <= '0;
    end else if (cfg_we && int'(cfg_index) < NREGS) begin
      points_r[cfg_index] <= cfg_data;
    end
  end

  pcse_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_curve, .in_entry_index,
    .in_knot_distance, .in_coef_cubic, .in_coef_square, .in_coef_linear,
    .in_coef_const, .in_query_distance, .points_r,
    .job_valid, .job_ready, .job
  );

  pcse_ram #(.WIDTH(ROW_WIDTH), .DEPTH(STORE_DEPTH)) u_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_row), .raddr(rd_addr), .rdata(rd_row)
  );

  pcse_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .wr_en, .wr_addr, .wr_row,
    .rd_addr, .rd_row,
    .out_valid, .out_ready, .out_speed, .out_segment, .out_status
  );

endmodule

### src/pcse_checker.sv
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on pcse_pkg.
module pcse_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pcse_pkg::SPEED_WIDTH-1:0] out_speed,
  input logic [pcse_pkg::IDX_WIDTH-1:0]   out_segment,
  input logic [2:0]                       out_status
);
  import pcse_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed))
    else $error("result changed under stall");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'(ST_WRITE))
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'(ST_OK) |-> out_speed == '0 && out_segment == '0)
    else $error("error result not zero");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind piecewise_cubic_spline_eval_core pcse_checker u_chk (.*);

### verif/piecewise_cubic_spline_eval_core_test.sv
// Self-checking testbench for piecewise_cubic_spline_eval_core: table writes,
// knot count settings and spline evaluations checked against a local predictor.
// Depends on pcse_pkg and the RTL of the evaluator only.
module piecewise_cubic_spline_eval_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcse_pkg::*;

  typedef struct {
    op_t                          op;
    logic [CURVE_WIDTH-1:0]       curve;
    logic [IDX_WIDTH-1:0]         entry;
    logic [DIST_WIDTH-1:0]        knot;
    logic signed [COEF_WIDTH-1:0] a, b, c, d;
    logic [DIST_WIDTH-1:0]        query;
  } item_t;

  typedef struct {
    logic signed [SPEED_WIDTH-1:0] speed;
    logic [IDX_WIDTH-1:0]          segment;
    status_t                       status;
  } result_t;

  localparam logic signed [65:0] COEF_HI = 66'sh7F_FFFF_FFFF;
  localparam logic signed [65:0] COEF_LO = -66'sh80_0000_0000;

  logic clk, rst_n;
  logic in_valid, in_ready, in_op;
  logic [CURVE_WIDTH-1:0] in_curve;
  logic [IDX_WIDTH-1:0] in_entry_index;
  logic [DIST_WIDTH-1:0] in_knot_distance, in_query_distance;
  logic signed [COEF_WIDTH-1:0] in_coef_cubic, in_coef_square, in_coef_linear, in_coef_const;
  logic out_valid, out_ready;
  logic signed [SPEED_WIDTH-1:0] out_speed;
  logic [IDX_WIDTH-1:0] out_segment;
  logic [2:0] out_status;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  logic [DIST_WIDTH-1:0]        knot_tab [STORE_DEPTH];
  logic signed [COEF_WIDTH-1:0] cubic_tab [STORE_DEPTH];
  logic signed [COEF_WIDTH-1:0] square_tab [STORE_DEPTH];
  logic signed [COEF_WIDTH-1:0] linear_tab [STORE_DEPTH];
  logic signed [COEF_WIDTH-1:0] const_tab [STORE_DEPTH];
  int unsigned knot_count [NREGS];

  result_t pending_results [$];
  int errors = 0;
  bit idle_on = 1;
  int long_hold = 0;

  piecewise_cubic_spline_eval_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [COEF_WIDTH-1:0] clamp_coef(logic signed [65:0] v);
    if (v > COEF_HI) return COEF_HI[COEF_WIDTH-1:0];
    if (v < COEF_LO) return COEF_LO[COEF_WIDTH-1:0];
    return v[COEF_WIDTH-1:0];
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] horner_step(
      logic signed [COEF_WIDTH-1:0] acc, logic [DIST_WIDTH-1:0] dx,
      logic signed [COEF_WIDTH-1:0] coef);
    logic signed [65:0] prod;
    logic signed [COEF_WIDTH-1:0] scaled;
    prod = acc * $signed({1'b0, dx});
    scaled = clamp_coef(prod >>> DIST_FRAC_BITS);
    return clamp_coef(66'(scaled) + 66'(coef));
  endfunction

  function automatic result_t spline_predict(item_t it);
    result_t r;
    int unsigned base, num, left, right, mid, k;
    logic [DIST_WIDTH-1:0] dx;
    logic signed [COEF_WIDTH-1:0] acc;
    r.speed = '0;
    r.segment = '0;
    base = (it.curve >= NUM_CURVES) ? 0 : it.curve * MAX_POINTS;
    if (it.op == OP_WRITE) begin
      k = base + it.entry;
      knot_tab[k] = it.knot;
      cubic_tab[k] = it.a;
      square_tab[k] = it.b;
      linear_tab[k] = it.c;
      const_tab[k] = it.d;
      r.status = ST_WRITE;
      return r;
    end
    num = knot_count[base / MAX_POINTS];
    if (num > MAX_POINTS) num = MAX_POINTS;
    if (num < 2) begin
      r.status = ST_NOT_LOAD;
      return r;
    end
    if (it.query < knot_tab[base]) begin
      r.status = ST_BELOW;
      return r;
    end
    if (it.query > knot_tab[base + num - 1]) begin
      r.status = ST_ABOVE;
      return r;
    end
    left = 0;
    right = num - 1;
    while (left < right) begin
      mid = (left + right) / 2 + 1;
      if (it.query <= knot_tab[base + mid]) right = mid - 1;
      else left = mid;
    end
    k = base + left;
    dx = (it.query >= knot_tab[k]) ? it.query - knot_tab[k] : '0;
    acc = cubic_tab[k];
    acc = horner_step(acc, dx, square_tab[k]);
    acc = horner_step(acc, dx, linear_tab[k]);
    acc = horner_step(acc, dx, const_tab[k]);
    r.speed = acc[COEF_WIDTH-1:SPEED_SHIFT];
    r.segment = left[IDX_WIDTH-1:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] random_coef();
    logic signed [COEF_WIDTH-1:0] v;
    v = COEF_WIDTH'({$urandom, $urandom});
    if ($urandom_range(0, 9) < 7) v = v >>> $urandom_range(8, 39);
    return v;
  endfunction

  function automatic item_t random_write(int unsigned curve, int unsigned entry);
    item_t it;
    it.op = OP_WRITE;
    it.curve = CURVE_WIDTH'(curve);
    it.entry = IDX_WIDTH'(entry);
    it.knot = DIST_WIDTH'((entry << 19) + $urandom_range(0, 20'h7FFFF));
    it.a = random_coef();
    it.b = random_coef();
    it.c = random_coef();
    it.d = random_coef();
    it.query = DIST_WIDTH'($urandom);
    return it;
  endfunction

  function automatic item_t random_eval(int unsigned curve);
    item_t it;
    int unsigned base, num;
    logic [31:0] lo, hi;
    it = random_write(curve, $urandom_range(0, 31));
    it.op = OP_EVAL;
    base = (curve >= NUM_CURVES) ? 0 : curve * MAX_POINTS;
    num = knot_count[base / MAX_POINTS];
    if (num > MAX_POINTS) num = MAX_POINTS;
    if (num < 1) num = 1;
    lo = 32'(knot_tab[base]);
    hi = 32'(knot_tab[base + num - 1]);
    if (hi >= lo && $urandom_range(0, 9) != 0)
      it.query = DIST_WIDTH'(lo + $urandom % (hi - lo + 1));
    return it;
  endfunction

  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_op = it.op;
    in_curve = it.curve;
    in_entry_index = it.entry;
    in_knot_distance = it.knot;
    in_coef_cubic = it.a;
    in_coef_square = it.b;
    in_coef_linear = it.c;
    in_coef_const = it.d;
    in_query_distance = it.query;
    in_valid = 1;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(spline_predict(it));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_counts(int unsigned n0, int unsigned n1, int unsigned n2);
    int unsigned n [NREGS];
    n = '{n0, n1, n2};
    drain();
    for (int i = 0; i < NREGS; i++) begin
      cfg_we = 1;
      cfg_index = 2'(i);
      cfg_data = CFG_WIDTH'(n[i]);
      knot_count[i] = n[i] & 6'h3F;
      @(negedge clk);
    end
    cfg_we = 0;
  endtask

  task automatic test_unloaded();
    item_t it;
    for (int c = 0; c < 4; c++) begin
      it = random_eval(0);
      it.curve = CURVE_WIDTH'(c);
      send_item(it);
    end
  endtask

  task automatic test_fill_tables();
    for (int c = 0; c < 4; c++)
      for (int e = 0; e < MAX_POINTS; e++)
        if (c < 3 || e % 8 == 0) send_item(random_write(c, e));
  endtask

  task automatic test_directed();
    item_t it;
    set_counts(32, 2, 1);
    it = random_eval(0);
    it.query = knot_tab[0];
    send_item(it);
    it.query = knot_tab[31];
    send_item(it);
    it.query = 0;
    send_item(it);
    it.query = '1;
    send_item(it);
    it.curve = 3;
    it.query = knot_tab[5] + DIST_WIDTH'(1);
    send_item(it);
    it.curve = 2;
    send_item(it);
    it = random_write(1, 0);
    it.a = COEF_HI[COEF_WIDTH-1:0];
    it.b = it.a;
    it.c = it.a;
    it.d = it.a;
    send_item(it);
    it = random_eval(1);
    it.query = knot_tab[MAX_POINTS + 1];
    send_item(it);
    it = random_write(1, 0);
    it.a = COEF_LO[COEF_WIDTH-1:0];
    it.b = it.a;
    it.c = it.a;
    it.d = it.a;
    send_item(it);
    it = random_eval(1);
    it.query = knot_tab[MAX_POINTS + 1];
    send_item(it);
    it = random_write(2, 31);
    it.knot = '1;
    send_item(it);
    set_counts(0, 32, 63);
    it = random_eval(2);
    it.query = '1;
    send_item(it);
    it.query = knot_tab[2 * MAX_POINTS] - DIST_WIDTH'(1);
    send_item(it);
    send_item(random_eval(0));
    send_item(random_eval(1));
  endtask

  task automatic test_random_phase(int unsigned items);
    item_t it;
    int unsigned n [NREGS];
    for (int i = 0; i < NREGS; i++)
      n[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 32);
    set_counts(n[0], n[1], n[2]);
    repeat (items) begin
      if ($urandom_range(0, 4) == 0) begin
        it = random_write($urandom_range(0, 3), $urandom_range(0, 31));
        if ($urandom_range(0, 2) == 0) it.knot = DIST_WIDTH'($urandom);
        if ($urandom_range(0, 3) == 0) it.a = COEF_WIDTH'({$urandom, $urandom});
      end else begin
        it = random_eval($urandom_range(0, 3));
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    drain();
    long_hold = 300;
    repeat (20) send_item(random_eval($urandom_range(0, 2)));
    drain();
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_speed !== exp_r.speed) begin
          $error("speed expected %0d actual %0d", exp_r.speed, out_speed);
          errors++;
        end
        if (out_segment !== exp_r.segment) begin
          $error("segment expected %0d actual %0d", exp_r.segment, out_segment);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_ready = 0;
        long_hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ready = 1;
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_op = 0;
    in_curve = 0;
    in_entry_index = 0;
    in_knot_distance = 0;
    in_coef_cubic = 0;
    in_coef_square = 0;
    in_coef_linear = 0;
    in_coef_const = 0;
    in_query_distance = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    knot_count = '{0, 0, 0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_unloaded();
    test_fill_tables();
    test_directed();
    repeat (8) test_random_phase(100);
    test_backpressure();
    idle_on = 0;
    test_random_phase(100);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
